/* rtl/core/stq_pkg.sv */
// Package for the sorted timeout queue: sizes, command and result codes,
// and the request/response structs between the controller and timer store.
// No dependencies.
package stq_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int POOL       = (NUM_TIMERS < 32) ? NUM_TIMERS : 32;
  localparam int ID_W       = 5;
  localparam int CNT_W      = 6;

  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_INIT  = 3'd1;
  localparam logic [2:0] CMD_SET   = 3'd2;
  localparam logic [2:0] CMD_FREE  = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [1:0] KIND_GRANT   = 2'd0;
  localparam logic [1:0] KIND_FAIL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_ARMED = 2'd2;

  localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

  typedef struct packed {
    logic [ID_W-1:0] rd_addr;
    logic [ID_W-1:0] wr_addr;
    logic            dl_we;
    logic            info_we;
    logic            st_we;
    logic [1:0]      st_wdata;
    logic [31:0]     dl_wdata;
    logic [3:0]      q_wdata;
    logic [31:0]     pay_wdata;
  } tm_req_t;

  typedef struct packed {
    logic [31:0]     dl_rdata;
    logic [3:0]      q_rdata;
    logic [31:0]     pay_rdata;
    logic            free_found;
    logic [ID_W-1:0] free_id;
  } tm_rsp_t;

endpackage

/* rtl/core/stq_if.sv */
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
interface stq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [4:0]         timer_id;
  logic [31:0]        delay_ticks;
  logic [3:0]         dest_queue;
  logic signed [31:0] payload;
  modport source (output valid, command, timer_id, delay_ticks, dest_queue, payload,
                  input ready);
  modport sink (input valid, command, timer_id, delay_ticks, dest_queue, payload,
                output ready);
endinterface

interface stq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [4:0]         granted_or_expired_id;
  logic [3:0]         out_queue;
  logic signed [31:0] out_payload;
  logic               last;
  modport source (output valid, kind, granted_or_expired_id, out_queue, out_payload, last,
                  input ready);
  modport sink (input valid, kind, granted_or_expired_id, out_queue, out_payload, last,
                output ready);
endinterface

/* rtl/core/stq_timer_mem.sv */
// Per-timer store: deadline and queue/payload memories, state flops and
// the first-free search for alloc. Depends on stq_pkg.
module stq_timer_mem (
  input  logic            clk,
  input  logic            rst,
  input  stq_pkg::tm_req_t req,
  output stq_pkg::tm_rsp_t rsp
);
  import stq_pkg::*;

  logic [31:0] dl_mem   [NUM_TIMERS];
  logic [3:0]  q_mem    [NUM_TIMERS];
  logic [31:0] pay_mem  [NUM_TIMERS];
  logic [1:0]  tstate   [NUM_TIMERS];
  logic [31:0] dl_rd;
  logic [3:0]  q_rd;
  logic [31:0] pay_rd;
  logic        found;
  logic [ID_W-1:0] fid;

  always_ff @(posedge clk) begin
    if (req.dl_we) begin
      dl_mem[req.wr_addr] <= req.dl_wdata;
    end
    if (req.info_we) begin
      q_mem[req.wr_addr]   <= req.q_wdata;
      pay_mem[req.wr_addr] <= req.pay_wdata;
    end
    dl_rd  <= dl_mem[req.rd_addr];
    q_rd   <= q_mem[req.rd_addr];
    pay_rd <= pay_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        tstate[k] <= ST_FREE;
      end
    end else if (req.st_we) begin
      tstate[req.wr_addr] <= req.st_wdata;
    end
  end

  // lowest free timer wins
  always_comb begin
    found = 1'b0;
    fid   = '0;
    for (int k = POOL - 1; k >= 0; k--) begin
      if (tstate[k] == ST_FREE) begin
        found = 1'b1;
        fid   = ID_W'(k);
      end
    end
  end

  assign rsp.dl_rdata   = dl_rd;
  assign rsp.q_rdata    = q_rd;
  assign rsp.pay_rdata  = pay_rd;
  assign rsp.free_found = found;
  assign rsp.free_id    = fid;

endmodule

/* rtl/core/stq_ctrl.sv */
// Command sequencer with the sorted order list memory and result register.
// Depends on stq_pkg and stq_if.
module stq_ctrl (
  input  logic             clk,
  input  logic             rst,
  stq_in_if.sink           in_ch,
  stq_out_if.source        out_ch,
  output stq_pkg::tm_req_t tm_req,
  input  stq_pkg::tm_rsp_t tm_rsp
);
  import stq_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_EXEC    = 5'd1;
  localparam logic [4:0] S_UNL_RD  = 5'd2;
  localparam logic [4:0] S_UNL_CHK = 5'd3;
  localparam logic [4:0] S_INS     = 5'd4;
  localparam logic [4:0] S_INS_O   = 5'd5;
  localparam logic [4:0] S_INS_D   = 5'd6;
  localparam logic [4:0] S_CNT_RD  = 5'd7;
  localparam logic [4:0] S_CNT_O   = 5'd8;
  localparam logic [4:0] S_CNT_D   = 5'd9;
  localparam logic [4:0] S_EM_RD   = 5'd10;
  localparam logic [4:0] S_EM_O    = 5'd11;
  localparam logic [4:0] S_EM_D    = 5'd12;
  localparam logic [4:0] S_CMP     = 5'd13;
  localparam logic [4:0] S_CMP_W   = 5'd14;
  localparam logic [4:0] S_REF     = 5'd15;
  localparam logic [4:0] S_REF_O   = 5'd16;
  localparam logic [4:0] S_REF_D   = 5'd17;

  logic [4:0]       state;
  logic [2:0]       cmd;
  logic [ID_W-1:0]  id;
  logic [31:0]      dl;
  logic [3:0]       q;
  logic [31:0]      pay;
  logic [31:0]      tick_count;
  logic [31:0]      next_deadline;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] w;
  logic [ID_W-1:0]  ent;
  logic [31:0]      tick_next;

  logic [ID_W-1:0]  order_mem [NUM_TIMERS];
  logic [ID_W-1:0]  ord_rd;
  logic [ID_W-1:0]  ord_ra;
  logic [ID_W-1:0]  ord_wa;
  logic [ID_W-1:0]  ord_wd;
  logic             ord_we;

  logic             ov;
  logic [1:0]       o_kind;
  logic [ID_W-1:0]  o_id;
  logic [3:0]       o_q;
  logic [31:0]      o_pay;
  logic             o_last;
  logic             slot_free;
  logic             emit;
  logic             id_ok;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] pos_n;

  assign slot_free = !ov || out_ch.ready;
  assign emit      = slot_free && ((state == S_EXEC && cmd == CMD_ALLOC) || state == S_EM_D);
  assign id_ok     = {1'b0, id} < CNT_W'(POOL);
  assign pos_m1    = pos - CNT_W'(1);
  assign pos_n     = pos + n;
  assign tick_next = tick_count + 32'd1;
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_wa] <= ord_wd;
    end
    ord_rd <= order_mem[ord_ra];
  end

  always_comb begin
    ord_ra = '0;
    ord_we = 1'b0;
    ord_wa = pos[ID_W-1:0];
    ord_wd = id;
    case (state)
      S_UNL_RD:  ord_ra = pos[ID_W-1:0];
      S_UNL_CHK: begin
        ord_we = (ord_rd != id);
        ord_wa = w[ID_W-1:0];
        ord_wd = ord_rd;
      end
      S_INS: begin
        ord_ra = pos_m1[ID_W-1:0];
        ord_we = (pos == '0);
      end
      S_INS_D: begin
        ord_we = 1'b1;
        ord_wd = (tm_rsp.dl_rdata > dl) ? ent : id;
      end
      S_CNT_RD:  ord_ra = n[ID_W-1:0];
      S_EM_RD:   ord_ra = pos[ID_W-1:0];
      S_CMP:     ord_ra = pos_n[ID_W-1:0];
      S_CMP_W: begin
        ord_we = 1'b1;
        ord_wd = ord_rd;
      end
      default: ord_ra = '0;
    endcase
  end

  always_comb begin
    tm_req           = '0;
    tm_req.rd_addr   = ent;
    tm_req.wr_addr   = id;
    tm_req.dl_wdata  = dl;
    tm_req.q_wdata   = q;
    tm_req.pay_wdata = pay;
    case (state)
      S_INS_O, S_CNT_O, S_EM_O, S_REF_O: tm_req.rd_addr = ord_rd;
      S_EXEC: begin
        case (cmd)
          CMD_ALLOC: begin
            tm_req.st_we    = slot_free && tm_rsp.free_found;
            tm_req.wr_addr  = tm_rsp.free_id;
            tm_req.st_wdata = ST_ALLOC;
          end
          CMD_INIT: tm_req.info_we = id_ok;
          CMD_SET: begin
            tm_req.dl_we    = id_ok;
            tm_req.st_we    = id_ok;
            tm_req.st_wdata = ST_ARMED;
          end
          CMD_FREE: begin
            tm_req.st_we    = id_ok;
            tm_req.st_wdata = ST_FREE;
          end
          default: tm_req.st_we = 1'b0;
        endcase
      end
      S_EM_D: begin
        tm_req.st_we    = slot_free;
        tm_req.wr_addr  = ent;
        tm_req.st_wdata = ST_ALLOC;
      end
      default: tm_req.st_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_count    <= '0;
      next_deadline <= NO_DEADLINE;
      cnt           <= '0;
      ov            <= 1'b0;
    end else begin
      if (emit) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd   <= in_ch.command;
            id    <= in_ch.timer_id;
            dl    <= tick_count + in_ch.delay_ticks;
            q     <= in_ch.dest_queue;
            pay   <= in_ch.payload;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          pos <= '0;
          w   <= '0;
          n   <= '0;
          case (cmd)
            CMD_ALLOC: begin
              if (slot_free) begin
                o_kind <= tm_rsp.free_found ? KIND_GRANT : KIND_FAIL;
                o_id   <= tm_rsp.free_found ? tm_rsp.free_id : '0;
                o_q    <= '0;
                o_pay  <= '0;
                o_last <= 1'b1;
                state  <= S_IDLE;
              end
            end
            CMD_SET: begin
              if (!id_ok) begin
                state <= S_IDLE;
              end else if (cnt == '0) begin
                state <= S_INS;
              end else begin
                state <= S_UNL_RD;
              end
            end
            CMD_TICK: begin
              tick_count <= tick_next;
              state      <= (next_deadline > tick_next) ? S_IDLE : S_CNT_RD;
            end
            default: state <= S_IDLE;
          endcase
        end
        // unlink: compact the list, dropping the timer being re-armed
        S_UNL_RD: state <= S_UNL_CHK;
        S_UNL_CHK: begin
          if (ord_rd != id) begin
            w <= w + CNT_W'(1);
          end
          pos <= pos + CNT_W'(1);
          if (pos + CNT_W'(1) == cnt) begin
            cnt   <= (ord_rd != id) ? w + CNT_W'(1) : w;
            pos   <= (ord_rd != id) ? w + CNT_W'(1) : w;
            state <= S_INS;
          end else begin
            state <= S_UNL_RD;
          end
        end
        // insert: walk back from the tail, shifting later deadlines up
        S_INS: begin
          if (pos == '0) begin
            cnt   <= cnt + CNT_W'(1);
            state <= S_REF;
          end else begin
            state <= S_INS_O;
          end
        end
        S_INS_O: begin
          ent   <= ord_rd;
          state <= S_INS_D;
        end
        S_INS_D: begin
          if (tm_rsp.dl_rdata > dl) begin
            pos   <= pos_m1;
            state <= S_INS;
          end else begin
            cnt   <= cnt + CNT_W'(1);
            state <= S_REF;
          end
        end
        // count expired entries at the head
        S_CNT_RD: begin
          if (n == cnt) begin
            pos   <= '0;
            state <= (n == '0) ? S_CMP : S_EM_RD;
          end else begin
            state <= S_CNT_O;
          end
        end
        S_CNT_O: begin
          ent   <= ord_rd;
          state <= S_CNT_D;
        end
        S_CNT_D: begin
          if (tm_rsp.dl_rdata > tick_count) begin
            pos   <= '0;
            state <= (n == '0) ? S_CMP : S_EM_RD;
          end else begin
            n     <= n + CNT_W'(1);
            state <= S_CNT_RD;
          end
        end
        S_EM_RD: state <= S_EM_O;
        S_EM_O: begin
          ent   <= ord_rd;
          state <= S_EM_D;
        end
        S_EM_D: begin
          if (slot_free) begin
            o_kind <= KIND_EXPIRED;
            o_id   <= ent;
            o_q    <= tm_rsp.q_rdata;
            o_pay  <= tm_rsp.pay_rdata;
            o_last <= (pos + CNT_W'(1) == n);
            if (pos + CNT_W'(1) == n) begin
              pos   <= '0;
              state <= S_CMP;
            end else begin
              pos   <= pos + CNT_W'(1);
              state <= S_EM_RD;
            end
          end
        end
        // shift the survivors down by the expired count
        S_CMP: begin
          if (pos_n >= cnt) begin
            cnt   <= cnt - n;
            state <= S_REF;
          end else begin
            state <= S_CMP_W;
          end
        end
        S_CMP_W: begin
          pos   <= pos + CNT_W'(1);
          state <= S_CMP;
        end
        S_REF: begin
          if (cnt == '0) begin
            next_deadline <= NO_DEADLINE;
            state         <= S_IDLE;
          end else begin
            state <= S_REF_O;
          end
        end
        S_REF_O: begin
          ent   <= ord_rd;
          state <= S_REF_D;
        end
        S_REF_D: begin
          next_deadline <= tm_rsp.dl_rdata;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid                 = ov;
  assign out_ch.kind                  = o_kind;
  assign out_ch.granted_or_expired_id = o_id;
  assign out_ch.out_queue             = o_q;
  assign out_ch.out_payload           = o_pay;
  assign out_ch.last                  = o_last;

endmodule

/* rtl/core/sorted_timeout_queue.sv */
// Sorted timeout queue, one command at a time; a new command is taken only in idle.
// Set unlinks any old entry of the timer from the sorted list, then walks back from
// the tail, shifting later deadlines up; tick advances the tick count and, when the
// next deadline is due, emits the expired timers (stalling on result back-pressure).
// Synchronous reset clears tick count, list length, next deadline and all
// timer states to free; deadline, queue and payload memories are not cleared.
module sorted_timeout_queue (
  input  logic      clk,
  input  logic      rst,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);
  import stq_pkg::*;

  tm_req_t tm_req;
  tm_rsp_t tm_rsp;

  stq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .tm_req (tm_req),
    .tm_rsp (tm_rsp)
  );

  stq_timer_mem u_tmem (
    .clk (clk),
    .rst (rst),
    .req (tm_req),
    .rsp (tm_rsp)
  );

endmodule

/* verif/tb_top.sv */
// Testbench for sorted_timeout_queue: directed and random command streams.
// Results are checked against an in-bench predictor of the timer list.
// Depends on stq_pkg and the stq_in_if / stq_out_if interfaces.
`timescale 1ns / 100ps

module tb_top;
  import stq_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic [4:0]         id;
    logic [3:0]         queue;
    logic signed [31:0] pay;
    logic               last;
  } timer_event_t;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst;
  stq_in_if  cmd_ch ();
  stq_out_if evt_ch ();

  sorted_timeout_queue i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch.sink),
    .out_ch (evt_ch.source)
  );

  // predicted timer pool
  logic [31:0] now_cnt;
  logic [31:0] earliest;
  int          n_armed;
  logic [4:0]  order[NUM_TIMERS];
  logic [31:0] due[NUM_TIMERS];
  logic [1:0]  tstate[NUM_TIMERS];
  logic [3:0]  tqueue[NUM_TIMERS];
  logic [31:0] tpay[NUM_TIMERS];
  bit          inited[NUM_TIMERS];

  timer_event_t pending_events[$];
  int errors;
  int cycles;
  int n_sent;
  int n_checked;
  int snd_idle_pct;
  int rcv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[sorted_timeout_queue] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    evt_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void push_event(logic [1:0] k, logic [4:0] id, logic [3:0] q,
                                     logic [31:0] p, logic l);
    timer_event_t e;
    e.kind = k; e.id = id; e.queue = q; e.pay = p; e.last = l;
    pending_events.push_back(e);
  endfunction

  function automatic void refresh_earliest();
    earliest = (n_armed > 0) ? due[order[0]] : NO_DEADLINE;
  endfunction

  // Apply one accepted command to the predicted pool and queue its results.
  function automatic void apply_command(logic [2:0] cmd, logic [4:0] id, logic [31:0] dly,
                                        logic [3:0] q, logic [31:0] p);
    int i;
    int j;
    int k;
    int n;
    logic [31:0] dl;
    if (cmd == CMD_ALLOC) begin
      for (i = 0; i < POOL; i++) begin
        if (tstate[i] == ST_FREE) begin
          tstate[i] = ST_ALLOC;
          push_event(KIND_GRANT, i[4:0], 4'd0, 32'd0, 1'b1);
          return;
        end
      end
      push_event(KIND_FAIL, 5'd0, 4'd0, 32'd0, 1'b1);
    end else if (cmd == CMD_TICK) begin
      now_cnt++;
      if (earliest > now_cnt) return;
      for (n = 0; n < n_armed; n++)
        if (due[order[n]] > now_cnt) break;
      for (i = 0; i < n; i++) begin
        tstate[order[i]] = ST_ALLOC;
        push_event(KIND_EXPIRED, order[i], tqueue[order[i]], tpay[order[i]], i + 1 == n);
      end
      for (j = 0; j + n < n_armed; j++) order[j] = order[j + n];
      n_armed -= n;
      refresh_earliest();
    end else if (cmd == CMD_INIT && id < POOL) begin
      tqueue[id] = q;
      tpay[id] = p;
      inited[id] = 1'b1;
    end else if (cmd == CMD_SET && id < POOL) begin
      dl = now_cnt + dly;
      // drop any old entry of this timer
      k = 0;
      for (i = 0; i < n_armed; i++)
        if (order[i] != id) begin
          order[k] = order[i];
          k++;
        end
      n_armed = k;
      due[id] = dl;
      tstate[id] = ST_ARMED;
      for (i = 0; i < n_armed; i++)
        if (due[order[i]] > dl) break;
      for (j = n_armed; j > i; j--) order[j] = order[j - 1];
      order[i] = id;
      n_armed++;
      refresh_earliest();
    end else if (cmd == CMD_FREE && id < POOL) begin
      tstate[id] = ST_FREE;
    end
  endfunction

  task automatic send_command(input logic [2:0] cmd, input logic [4:0] id,
                              input logic [31:0] dly, input logic [3:0] q,
                              input logic [31:0] p);
    int gap;
    gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= cmd;
    cmd_ch.timer_id    <= id;
    cmd_ch.delay_ticks <= dly;
    cmd_ch.dest_queue  <= q;
    cmd_ch.payload     <= p;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    apply_command(cmd, id, dly, q, p);
    n_sent++;
  endtask

  always @(posedge clk) begin
    timer_event_t e;
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected result kind %0d id %0d", evt_ch.kind,
                         evt_ch.granted_or_expired_id));
      end else begin
        e = pending_events.pop_front();
        if (evt_ch.kind !== e.kind || evt_ch.granted_or_expired_id !== e.id ||
            evt_ch.out_queue !== e.queue || evt_ch.out_payload !== e.pay ||
            evt_ch.last !== e.last)
          report($sformatf("got k%0d id%0d q%0d p%0h l%0d, want k%0d id%0d q%0d p%0h l%0d",
                           evt_ch.kind, evt_ch.granted_or_expired_id, evt_ch.out_queue,
                           evt_ch.out_payload, evt_ch.last, e.kind, e.id, e.queue,
                           e.pay, e.last));
        n_checked++;
      end
    end
  end

  // Ordering, equal deadlines, re-arm, free while armed, wrapped deadlines.
  task automatic test_directed();
    send_command(CMD_ALLOC, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_ALLOC, 5'd31, 32'd0, 4'd0, 32'd0);
    send_command(CMD_INIT, 5'd0, 32'd0, 4'hf, 32'h7fff_ffff);
    send_command(CMD_INIT, 5'd1, 32'd0, 4'h0, 32'h8000_0000);
    send_command(CMD_SET, 5'd0, 32'd2, 4'd0, 32'd0);
    send_command(CMD_SET, 5'd1, 32'd2, 4'd0, 32'd0);
    send_command(CMD_SET, 5'd0, 32'd2, 4'd0, 32'd0);
    send_command(CMD_FREE, 5'd1, 32'd0, 4'd0, 32'd0);
    send_command(CMD_TICK, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_TICK, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_ALLOC, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(3'd7, 5'd31, 32'hffff_ffff, 4'hf, 32'hffff_ffff);
    send_command(3'd5, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_INIT, 5'd31, 32'd0, 4'ha, 32'hffff_ffff);
    send_command(CMD_SET, 5'd31, 32'hffff_ffff, 4'd0, 32'd0);
    send_command(CMD_SET, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_SET, 5'd1, 32'd1, 4'd0, 32'd0);
    send_command(CMD_TICK, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_TICK, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_TICK, 5'd0, 32'd0, 4'd0, 32'd0);
    send_command(CMD_FREE, 5'd31, 32'd0, 4'd0, 32'd0);
    send_command(CMD_ALLOC, 5'd0, 32'd0, 4'd0, 32'd0);
  endtask

  task automatic test_random(input int count);
    int r;
    int tries;
    logic [4:0]  id;
    logic [31:0] dly;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      id = 5'($urandom);
      if (r < 15) begin
        send_command(CMD_ALLOC, id, $urandom, 4'($urandom), $urandom);
      end else if (r < 33) begin
        send_command(CMD_INIT, id, $urandom, 4'($urandom), $urandom);
      end else if (r < 60) begin
        // arm only initialized timers, so every expiry has a known queue
        tries = 0;
        while (!inited[id] && tries < 64) begin
          id = 5'($urandom);
          tries++;
        end
        r = $urandom_range(99);
        if (r < 60) dly = $urandom_range(0, 6);
        else if (r < 80) dly = 32'hffff_ffff - $urandom_range(0, 3);
        else dly = $urandom;
        if (inited[id]) send_command(CMD_SET, id, dly, 4'($urandom), $urandom);
        else send_command(CMD_INIT, id, dly, 4'($urandom), $urandom);
      end else if (r < 70) begin
        send_command(CMD_FREE, id, $urandom, 4'($urandom), $urandom);
      end else if (r < 96) begin
        send_command(CMD_TICK, id, $urandom, 4'($urandom), $urandom);
      end else begin
        send_command(3'($urandom_range(5, 7)), id, $urandom, 4'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    now_cnt = 32'd0;
    earliest = NO_DEADLINE;
    n_armed = 0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      order[i] = '0; due[i] = '0; tstate[i] = ST_FREE;
      tqueue[i] = '0; tpay[i] = '0; inited[i] = 1'b0;
    end
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_ALLOC;
    cmd_ch.timer_id    = '0;
    cmd_ch.delay_ticks = '0;
    cmd_ch.dest_queue  = '0;
    cmd_ch.payload     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    snd_idle_pct = 18; rcv_idle_pct = 86;
    test_random(70);
    snd_idle_pct = 86; rcv_idle_pct = 18;
    test_random(70);
    snd_idle_pct = 0; rcv_idle_pct = 0;
    test_random(70);

    @(posedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("%0d commands sent, %0d results checked, tick count %0d, %0d timers armed",
             n_sent, n_checked, now_cnt, n_armed);
    if (errors == 0) begin
      $display("[sorted_timeout_queue] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[sorted_timeout_queue] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/stq_pkg.sv
rtl/core/stq_if.sv
rtl/core/stq_timer_mem.sv
rtl/core/stq_ctrl.sv
rtl/core/sorted_timeout_queue.sv
verif/tb_top.sv
